// File: rtl/sli_pkg.sv
`timescale 1ns / 1ps
// shared constants for the segment/line intersection core
// no dependencies

package sli_pkg;

  // default geometry formats
  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  // tolerance register width and register port shape
  localparam int TOL_BITS       = 16;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  // register indexes (word address bit 2)
  localparam logic REG_DET_TOL = 1'b0;
  localparam logic REG_T_TOL   = 1'b1;

endpackage

// File: rtl/sli_divider.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage
// standalone: no package dependencies; sideband rides along with each beat

module sli_divider #(
  parameter int DW  = 51,
  parameter int QB  = 17,
  parameter int SBW = 100
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rem,
  input  logic [QB-1:0]  in_low,
  input  logic [DW-1:0]  in_div,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QB-1:0]  out_q,
  output logic           out_rem_nz,
  output logic [SBW-1:0] out_sb
);

  logic           vld  [0:QB];
  logic [DW-1:0]  rem  [0:QB];
  logic [QB-1:0]  low  [0:QB];
  logic [QB-1:0]  quo  [0:QB];
  logic [DW-1:0]  dvs  [0:QB];
  logic [SBW-1:0] sb   [0:QB];

  // stage zero is the input
  assign vld[0] = in_valid;
  assign rem[0] = in_rem;
  assign low[0] = in_low;
  assign quo[0] = '0;
  assign dvs[0] = in_div;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // shift in next dividend bit and try to subtract
    assign trial = {rem[k], low[k][QB-1]};
    assign diff  = trial - {1'b0, dvs[k]};
    assign ge    = trial >= {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low[k+1] <= {low[k][QB-2:0], 1'b0};
      quo[k+1] <= {quo[k][QB-2:0], ge};
      dvs[k+1] <= dvs[k];
      sb[k+1]  <= sb[k];
    end
  end

  assign out_valid  = vld[QB];
  assign out_q      = quo[QB];
  assign out_rem_nz = |rem[QB];
  assign out_sb     = sb[QB];

endmodule

// File: rtl/segment_line_intersection_core.sv
`timescale 1ns / 1ps
// segment_line_intersection_core: start runs through stages 1 to 6, the divider, stages 7 and 8
// and the result register to done. QB = max(T_FRAC_BITS, 16) + 1 is the quotient width of
// the one-bit-per-stage divider; throughput is one beat per cycle, busy stays low.
// done pulses for one cycle and cannot be held off by the receiver.
// rst is synchronous: it clears the pipeline valid bits and both tolerance registers.
// depends on sli_pkg and sli_divider

module segment_line_intersection_core #(
  parameter int COORD_BITS  = sli_pkg::COORD_BITS,
  parameter int T_FRAC_BITS = sli_pkg::T_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        seg_start_x,
  input  logic signed [COORD_BITS-1:0]        seg_start_y,
  input  logic signed [COORD_BITS-1:0]        seg_end_x,
  input  logic signed [COORD_BITS-1:0]        seg_end_y,
  input  logic signed [COORD_BITS-1:0]        line_start_x,
  input  logic signed [COORD_BITS-1:0]        line_start_y,
  input  logic signed [COORD_BITS-1:0]        line_end_x,
  input  logic signed [COORD_BITS-1:0]        line_end_y,
  // result channel
  output logic                                done,
  output logic                                hit,
  output logic signed [COORD_BITS-1:0]        point_x,
  output logic signed [COORD_BITS-1:0]        point_y,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sli_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [sli_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [sli_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  localparam int C    = COORD_BITS;
  localparam int F    = T_FRAC_BITS;
  localparam int TW   = sli_pkg::TOL_BITS;
  localparam int DFW  = C + 1;
  localparam int PRW  = 2 * DFW;
  localparam int DW   = PRW + 1;
  localparam int QB   = ((F > TW) ? F : TW) + 1;
  localparam int XW   = DW + F;
  localparam int PTW  = DW + TW;
  localparam int LW   = ((XW > PTW) ? XW : PTW) + 1;
  localparam int TQW  = QB + 1;
  localparam int MW   = TQW + DFW;
  localparam int SW   = MW + 2;
  localparam int SBW  = 2 + 2 * C + 2 * DFW;

  // register file
  logic [TW-1:0] det_tol;
  logic [TW-1:0] t_tol;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_tol <= '0;
      t_tol   <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        sli_pkg::REG_DET_TOL: det_tol <= pwdata[TW-1:0];
        sli_pkg::REG_T_TOL:   t_tol   <= pwdata[TW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sli_pkg::REG_DET_TOL: prdata = {{(sli_pkg::APB_DATA_BITS-TW){1'b0}}, det_tol};
      sli_pkg::REG_T_TOL:   prdata = {{(sli_pkg::APB_DATA_BITS-TW){1'b0}}, t_tol};
    endcase
  end

  // fully pipelined, never stalls
  assign busy = 1'b0;

  // stage 1: direction and offset vectors
  logic                  v1;
  logic signed [C-1:0]   sx1, sy1;
  logic signed [DFW-1:0] ex1, ey1, dx1, dy1, bx1, by1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    sx1 <= seg_start_x;
    sy1 <= seg_start_y;
    ex1 <= $signed({seg_end_x[C-1], seg_end_x}) - $signed({seg_start_x[C-1], seg_start_x});
    ey1 <= $signed({seg_end_y[C-1], seg_end_y}) - $signed({seg_start_y[C-1], seg_start_y});
    dx1 <= $signed({line_end_x[C-1], line_end_x})
         - $signed({line_start_x[C-1], line_start_x});
    dy1 <= $signed({line_end_y[C-1], line_end_y})
         - $signed({line_start_y[C-1], line_start_y});
    bx1 <= $signed({seg_start_x[C-1], seg_start_x})
         - $signed({line_start_x[C-1], line_start_x});
    by1 <= $signed({seg_start_y[C-1], seg_start_y})
         - $signed({line_start_y[C-1], line_start_y});
  end

  // stage 2: four cross products
  logic                  v2;
  logic signed [C-1:0]   sx2, sy2;
  logic signed [DFW-1:0] ex2, ey2;
  logic signed [PRW-1:0] pa2, pb2, pc2, pd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sx2 <= sx1;
    sy2 <= sy1;
    ex2 <= ex1;
    ey2 <= ey1;
    pa2 <= ex1 * dy1;
    pb2 <= dx1 * ey1;
    pc2 <= dx1 * by1;
    pd2 <= dy1 * bx1;
  end

  // stage 3: determinant and numerator
  logic                  v3;
  logic signed [C-1:0]   sx3, sy3;
  logic signed [DFW-1:0] ex3, ey3;
  logic signed [DW-1:0]  det3, num3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sx3  <= sx2;
    sy3  <= sy2;
    ex3  <= ex2;
    ey3  <= ey2;
    det3 <= DW'(pa2) - DW'(pb2);
    num3 <= DW'(pc2) - DW'(pd2);
  end

  // stage 4: make determinant positive, parallel test
  logic                  v4, par4;
  logic signed [C-1:0]   sx4, sy4;
  logic signed [DFW-1:0] ex4, ey4;
  logic [DW-1:0]         detm4;
  logic signed [DW-1:0]  numn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    sx4   <= sx3;
    sy4   <= sy3;
    ex4   <= ex3;
    ey4   <= ey3;
    detm4 <= det3[DW-1] ? DW'(-det3) : DW'(det3);
    numn4 <= det3[DW-1] ? -num3 : num3;
    par4  <= (det3[DW-1] ? DW'(-det3) : DW'(det3)) <= DW'(det_tol);
  end

  // stage 5: tolerance band width det * t_tol, numerator magnitude
  logic                  v5, par5, nneg5;
  logic signed [C-1:0]   sx5, sy5;
  logic signed [DFW-1:0] ex5, ey5;
  logic [DW-1:0]         detm5, nabs5;
  logic [PTW-1:0]        pt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sx5   <= sx4;
    sy5   <= sy4;
    ex5   <= ex4;
    ey5   <= ey4;
    par5  <= par4;
    detm5 <= detm4;
    nneg5 <= numn4[DW-1];
    nabs5 <= numn4[DW-1] ? DW'(-numn4) : DW'(numn4);
    pt5   <= PTW'(detm4) * PTW'(t_tol);
  end

  // stage 6: exact range test on t, divider setup
  logic [XW-1:0]  xmag;
  logic [LW-1:0]  lim;
  logic           in_range;

  assign xmag     = {nabs5, {F{1'b0}}};
  assign lim      = nneg5 ? LW'(pt5) : LW'({detm5, {F{1'b0}}}) + LW'(pt5);
  assign in_range = LW'(xmag) <= lim;

  logic                  v6;
  logic [DW-1:0]         rem6, det6;
  logic [QB-1:0]         low6;
  logic [SBW-1:0]        sb6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    rem6 <= DW'(xmag >> QB);
    low6 <= xmag[QB-1:0];
    det6 <= detm5;
    sb6  <= {!par5 && in_range, nneg5, sx5, sy5, ex5, ey5};
  end

  // quotient floor(|num| * 2^F / det)
  logic           vd;
  logic [QB-1:0]  qd;
  logic           rnz;
  logic [SBW-1:0] sbd;

  sli_divider #(
    .DW  (DW),
    .QB  (QB),
    .SBW (SBW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v6),
    .in_rem     (rem6),
    .in_low     (low6),
    .in_div     (det6),
    .in_sb      (sb6),
    .out_valid  (vd),
    .out_q      (qd),
    .out_rem_nz (rnz),
    .out_sb     (sbd)
  );

  logic                  okd, nnegd;
  logic signed [C-1:0]   sxd, syd;
  logic signed [DFW-1:0] exd, eyd;

  assign {okd, nnegd, sxd, syd, exd, eyd} = sbd;

  // stage 7: signed floor quotient
  logic                  v7, ok7;
  logic signed [C-1:0]   sx7, sy7;
  logic signed [DFW-1:0] ex7, ey7;
  logic signed [TQW-1:0] tq7;
  logic signed [TQW-1:0] qpos;

  assign qpos = $signed({1'b0, qd});

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= vd;
    end
    ok7 <= okd;
    sx7 <= sxd;
    sy7 <= syd;
    ex7 <= exd;
    ey7 <= eyd;
    tq7 <= nnegd ? (-qpos - $signed({{(TQW-1){1'b0}}, rnz})) : qpos;
  end

  // stage 8: tq times segment direction
  logic                  v8, ok8;
  logic signed [C-1:0]   sx8, sy8;
  logic signed [MW-1:0]  mx8, my8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    ok8 <= ok7;
    sx8 <= sx7;
    sy8 <= sy7;
    mx8 <= MW'(tq7) * MW'(ex7);
    my8 <= MW'(tq7) * MW'(ey7);
  end

  // stage 9: round to nearest, add start point, saturate
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] SMAX = $signed({{(SW-C+1){1'b0}}, {(C-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = $signed({{(SW-C+1){1'b1}}, {(C-1){1'b0}}});

  logic signed [SW-1:0] rx, ry, sumx, sumy;
  logic signed [C-1:0]  satx, saty;

  assign rx   = (SW'(mx8) + HALF) >>> F;
  assign ry   = (SW'(my8) + HALF) >>> F;
  assign sumx = SW'(sx8) + rx;
  assign sumy = SW'(sy8) + ry;

  always_comb begin
    priority if (sumx > SMAX) begin
      satx = SMAX[C-1:0];
    end else if (sumx < SMIN) begin
      satx = SMIN[C-1:0];
    end else begin
      satx = sumx[C-1:0];
    end
    priority if (sumy > SMAX) begin
      saty = SMAX[C-1:0];
    end else if (sumy < SMIN) begin
      saty = SMIN[C-1:0];
    end else begin
      saty = sumy[C-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v8;
    end
    hit     <= ok8;
    point_x <= ok8 ? satx : '0;
    point_y <= ok8 ? saty : '0;
  end

endmodule
